@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AADC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AADC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/aadc_pkg.sv @@
// shared constants and types of the axis conditioner
`timescale 1ns / 1ps
`default_nettype none

package aadc_pkg;

  // raw sample is sign extended from this many low bits of the input field
  localparam int SAMPLE_BITS    = 16;
  localparam int RAW_W          = 16;
  localparam int VAL_W          = 16;
  // internal values carry one more bit so that 1.0 is representable
  localparam int FRAC_W         = VAL_W + 1;
  localparam int DEADZONE_LIMIT = 32768;
  localparam int CENTER_Q16     = 32768;
  localparam int ONE_Q16        = 65536;
  // smallest usable deadzone gap, 0.0001 in Q0.16 rounded up
  localparam int MIN_GAP        = 7;
  localparam int SCALE_STEPS    = VAL_W;
  localparam int DZ_STEPS       = $clog2(CENTER_Q16);
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_ENABLE     = 3'd0,
    CFG_AXIS_MIN        = 3'd1,
    CFG_AXIS_MAX        = 3'd2,
    CFG_GAIN            = 3'd3,
    CFG_DEADZONE        = 3'd4,
    CFG_DEADZONE_ENABLE = 3'd5,
    CFG_REVERSE         = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic               axis_enable;
    logic signed [15:0] axis_min;
    logic signed [15:0] axis_max;
    logic [15:0]        gain;
    logic [14:0]        deadzone;
    logic               deadzone_enable;
    logic               reverse;
  } cfg_t;

  // scaled fraction leaving the range divider
  typedef struct packed {
    logic              span_err;
    logic [FRAC_W-1:0] s;
  } scaled_t;

  // fraction after deadzone shaping
  typedef struct packed {
    logic              span_err;
    logic              snap;
    logic [FRAC_W-1:0] s;
  } shaped_t;

endpackage

`default_nettype wire

@@ rtl/aadc_scale.sv @@
// gain multiply, offset and range division to a Q0.16 fraction
`timescale 1ns / 1ps
`default_nettype none

module aadc_scale (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_vld,
  input  wire logic [aadc_pkg::RAW_W-1:0] raw,
  input  wire aadc_pkg::cfg_t        cfg,
  output logic                       out_vld,
  output aadc_pkg::scaled_t          out_data
);

  localparam int N     = aadc_pkg::SCALE_STEPS;
  localparam int DVS_W = aadc_pkg::VAL_W + 8;
  localparam int SB    = aadc_pkg::SAMPLE_BITS;

  typedef enum logic [1:0] {
    SK_DIV  = 2'd0,
    SK_ZERO = 2'd1,
    SK_FULL = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  span_err;
  } tag_t;

  // static range terms; config is to change only while idle, a rule on the user that this block leaves unchecked
  logic signed [16:0] span;
  logic               span_neg;
  logic [16:0]        span_abs;
  logic [DVS_W-1:0]   dvs;
  logic signed [33:0] min_sh;

  assign span     = {cfg.axis_max[15], cfg.axis_max} - {cfg.axis_min[15], cfg.axis_min};
  assign span_neg = span[16];
  assign span_abs = span_neg ? (~span + 17'd1) : span;
  assign dvs      = {span_abs[15:0], 8'd0};
  assign min_sh   = {{10{cfg.axis_min[15]}}, cfg.axis_min, 8'd0};

  // stage 1: raw times gain
  logic signed [16:0] raw_x;
  logic signed [16:0] gain_x;
  logic signed [33:0] prod_nxt;
  logic               vld1_r;
  logic signed [33:0] prod_r;

  assign raw_x    = {{(17-SB){raw[SB-1]}}, raw[SB-1:0]};
  assign gain_x   = {1'b0, cfg.gain};
  assign prod_nxt = raw_x * gain_x;

  // stage 2: remove the minimum, fold the span sign into the numerator
  logic signed [33:0] num_nxt;
  logic               vld2_r;
  logic signed [33:0] num_r;

  assign num_nxt = span_neg ? (min_sh - prod_r) : (prod_r - min_sh);

  // stage 3: classify against 0 and 1.0, seed the divider
  logic               nonpos;
  logic               full;
  tag_t               tag_nxt;

  assign nonpos = num_r[33] || (num_r == '0);
  assign full   = num_r[32:0] >= {9'd0, dvs};

  always_comb begin
    tag_nxt.span_err = (span == '0);
    if (span == '0) begin
      tag_nxt.kind = SK_ZERO;
    end else if (nonpos) begin
      tag_nxt.kind = SK_ZERO;
    end else if (full) begin
      tag_nxt.kind = SK_FULL;
    end else begin
      tag_nxt.kind = SK_DIV;
    end
  end

  // restoring divider, one quotient bit per stage
  logic             vld_r [0:N];
  tag_t             tag_r [0:N];
  logic [DVS_W-1:0] rem_r [0:N];
  logic [N-1:0]     quo_r [0:N];
  logic [DVS_W:0]   dbl   [1:N];
  logic             ge    [1:N];
  logic [DVS_W-1:0] rem_nxt [1:N];
  logic [N-1:0]     quo_nxt [1:N];

  always_comb begin
    for (int k = 1; k <= N; k++) begin
      dbl[k]     = {rem_r[k-1], 1'b0};
      ge[k]      = dbl[k] >= {1'b0, dvs};
      rem_nxt[k] = ge[k] ? DVS_W'(dbl[k] - {1'b0, dvs}) : dbl[k][DVS_W-1:0];
      quo_nxt[k] = {quo_r[k-1][N-2:0], ge[k]};
    end
  end

  // final stage: pick 0, 1.0 or the quotient
  logic                      vldo_r;
  aadc_pkg::scaled_t         out_r;
  aadc_pkg::scaled_t         out_nxt;

  always_comb begin
    out_nxt.span_err = tag_r[N].span_err;
    unique case (tag_r[N].kind)
      SK_ZERO: out_nxt.s = '0;
      SK_FULL: out_nxt.s = aadc_pkg::FRAC_W'(aadc_pkg::ONE_Q16);
      SK_DIV:  out_nxt.s = {1'b0, quo_r[N]};
      default: out_nxt.s = '0;
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vldo_r <= 1'b0;
      for (int k = 0; k <= N; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld1_r   <= in_vld;
      vld2_r   <= vld1_r;
      vld_r[0] <= vld2_r;
      for (int k = 1; k <= N; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      vldo_r <= vld_r[N];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt;
      num_r    <= num_nxt;
      tag_r[0] <= tag_nxt;
      rem_r[0] <= num_r[DVS_W-1:0];
      quo_r[0] <= '0;
      for (int k = 1; k <= N; k++) begin
        tag_r[k] <= tag_r[k-1];
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
      out_r <= out_nxt;
    end
  end

  assign out_vld  = vldo_r;
  assign out_data = out_r;

endmodule

`default_nettype wire

@@ rtl/aadc_deadzone.sv @@
// deadzone snap and rescale of the Q0.16 fraction
`timescale 1ns / 1ps
`default_nettype none

module aadc_deadzone (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire aadc_pkg::scaled_t in_data,
  input  wire aadc_pkg::cfg_t    cfg,
  output logic                   out_vld,
  output aadc_pkg::shaped_t      out_data
);

  localparam int N = aadc_pkg::DZ_STEPS;
  localparam int W = aadc_pkg::FRAC_W;
  localparam logic [W-1:0] LIMIT  = W'(aadc_pkg::DEADZONE_LIMIT);
  localparam logic [W-1:0] CENTER = W'(aadc_pkg::CENTER_Q16);
  localparam logic [W-1:0] MINGAP = W'(aadc_pkg::MIN_GAP);

  typedef enum logic [1:0] {
    DM_PASS = 2'd0,
    DM_SNAP = 2'd1,
    DM_SAT  = 2'd2,
    DM_DIV  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t        mode;
    logic         above;
    logic         span_err;
    logic [W-1:0] s;
  } tag_t;

  // static deadzone terms
  logic [W-1:0] dz;
  logic         act;
  logic [W-1:0] gap;
  logic         gap_ok;

  assign dz     = W'(cfg.deadzone);
  assign act    = cfg.deadzone_enable && (cfg.deadzone != '0) && (dz < LIMIT);
  assign gap    = LIMIT - dz;
  assign gap_ok = gap >= MINGAP;

  // stage 1: distance from center
  logic         above_nxt;
  logic [W-1:0] mag_nxt;
  logic         v1_r;
  logic         above1_r;
  logic         err1_r;
  logic [W-1:0] s1_r;
  logic [W-1:0] mag1_r;

  assign above_nxt = in_data.s > CENTER;
  assign mag_nxt   = above_nxt ? (in_data.s - CENTER) : (CENTER - in_data.s);

  // stage 2: inside test and distance past the edge
  logic         v2_r;
  logic         above2_r;
  logic         err2_r;
  logic         snap2_r;
  logic [W-1:0] s2_r;
  logic [W-1:0] r2_r;

  // stage 3: choose how the value is formed
  tag_t tag_nxt;

  always_comb begin
    tag_nxt.above    = above2_r;
    tag_nxt.span_err = err2_r;
    tag_nxt.s        = s2_r;
    priority if (err2_r || !act) begin
      tag_nxt.mode = DM_PASS;
    end else if (snap2_r) begin
      tag_nxt.mode = DM_SNAP;
    end else if (!gap_ok) begin
      tag_nxt.mode = DM_PASS;
    end else if (r2_r >= gap) begin
      tag_nxt.mode = DM_SAT;
    end else begin
      tag_nxt.mode = DM_DIV;
    end
  end

  // restoring divider for the rescale offset, one bit per stage
  logic         vld_r [0:N];
  tag_t         tag_r [0:N];
  logic [W-1:0] rem_r [0:N];
  logic [N-1:0] quo_r [0:N];
  logic [W:0]   dbl   [1:N];
  logic         ge    [1:N];
  logic [W-1:0] rem_nxt [1:N];
  logic [N-1:0] quo_nxt [1:N];

  always_comb begin
    for (int k = 1; k <= N; k++) begin
      dbl[k]     = {rem_r[k-1], 1'b0};
      ge[k]      = dbl[k] >= {1'b0, gap};
      rem_nxt[k] = ge[k] ? W'(dbl[k] - {1'b0, gap}) : dbl[k][W-1:0];
      quo_nxt[k] = {quo_r[k-1][N-2:0], ge[k]};
    end
  end

  // final stage: pass, snap to center, or apply the offset on the proper side of center
  logic [W-1:0]      off;
  aadc_pkg::shaped_t out_nxt;
  aadc_pkg::shaped_t out_r;
  logic              vldo_r;

  assign off = (tag_r[N].mode == DM_SAT) ? CENTER : W'(quo_r[N]);

  always_comb begin
    out_nxt.span_err = tag_r[N].span_err;
    out_nxt.snap     = (tag_r[N].mode == DM_SNAP);
    unique case (tag_r[N].mode)
      DM_PASS:         out_nxt.s = tag_r[N].s;
      DM_SNAP:         out_nxt.s = CENTER;
      DM_SAT, DM_DIV:  out_nxt.s = tag_r[N].above ? (CENTER + off) : (CENTER - off);
      default:         out_nxt.s = tag_r[N].s;
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      vldo_r <= 1'b0;
      for (int k = 0; k <= N; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      v1_r     <= in_vld;
      v2_r     <= v1_r;
      vld_r[0] <= v2_r;
      for (int k = 1; k <= N; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      vldo_r <= vld_r[N];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      above1_r <= above_nxt;
      err1_r   <= in_data.span_err;
      s1_r     <= in_data.s;
      mag1_r   <= mag_nxt;
      above2_r <= above1_r;
      err2_r   <= err1_r;
      s2_r     <= s1_r;
      snap2_r  <= act && !err1_r && (mag1_r < dz);
      r2_r     <= mag1_r - dz;
      tag_r[0] <= tag_nxt;
      rem_r[0] <= r2_r;
      quo_r[0] <= '0;
      for (int k = 1; k <= N; k++) begin
        tag_r[k] <= tag_r[k-1];
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
      out_r <= out_nxt;
    end
  end

  assign out_vld  = vldo_r;
  assign out_data = out_r;

endmodule

`default_nettype wire

@@ rtl/analog_axis_deadzone_conditioner.sv @@
// top level of the analog axis conditioner: config registers, pipeline, output stage
`timescale 1ns / 1ps
`default_nettype none

// Conditions one raw joystick axis sample per request: gain (Q8.8), offset by
// the axis minimum, division by the axis span into an unsigned Q0.16 fraction
// clamped to 0..1.0, optional deadzone snap and rescale around center, optional
// reversal, 1.0 saturating to 65535. One request is taken every cycle while no
// stalled result holds the pipeline; each result passes through the two
// bit-per-stage restoring dividers (16 stages for the range division, 15 for
// the deadzone rescale) plus the multiplier and the classify stages. A stall
// on the result side freezes the whole pipeline. Requests seen while the axis
// is disabled are taken and give no result. Write the registers only while no
// request is in flight.

`include "assert_macros.svh"

module analog_axis_deadzone_conditioner (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [aadc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aadc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [aadc_pkg::RAW_W-1:0]      in_raw_sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [aadc_pkg::VAL_W-1:0]           out_axis_value,
  output logic                                 out_in_deadzone,
  output logic                                 out_span_error
);

  localparam int W = aadc_pkg::FRAC_W;

  // configuration registers
  aadc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis_enable     <= 1'b0;
      cfg_r.axis_min        <= 16'sd0;
      cfg_r.axis_max        <= 16'sd255;
      cfg_r.gain            <= 16'd256;
      cfg_r.deadzone        <= 15'd0;
      cfg_r.deadzone_enable <= 1'b0;
      cfg_r.reverse         <= 1'b0;
    end else if (cfg_we) begin
      unique case (aadc_pkg::cfg_idx_t'(cfg_index))
        aadc_pkg::CFG_AXIS_ENABLE:     cfg_r.axis_enable     <= cfg_wdata[0];
        aadc_pkg::CFG_AXIS_MIN:        cfg_r.axis_min        <= cfg_wdata;
        aadc_pkg::CFG_AXIS_MAX:        cfg_r.axis_max        <= cfg_wdata;
        aadc_pkg::CFG_GAIN:            cfg_r.gain            <= cfg_wdata;
        aadc_pkg::CFG_DEADZONE:        cfg_r.deadzone        <= cfg_wdata[14:0];
        aadc_pkg::CFG_DEADZONE_ENABLE: cfg_r.deadzone_enable <= cfg_wdata[0];
        aadc_pkg::CFG_REVERSE:         cfg_r.reverse         <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic out_vld_r;
  logic en;

  assign en       = !(out_vld_r && out_stall);
  assign in_stall = !en;

  // range scaling
  logic              sc_vld;
  aadc_pkg::scaled_t sc_data;

  aadc_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid && en && cfg_r.axis_enable),
    .raw      (in_raw_sample),
    .cfg      (cfg_r),
    .out_vld  (sc_vld),
    .out_data (sc_data)
  );

  // deadzone shaping
  logic              dz_vld;
  aadc_pkg::shaped_t dz_data;

  aadc_deadzone u_deadzone (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sc_vld),
    .in_data  (sc_data),
    .cfg      (cfg_r),
    .out_vld  (dz_vld),
    .out_data (dz_data)
  );

  // reverse, saturate, zero on span error and register the result
  logic [W-1:0]                rev;
  logic [aadc_pkg::VAL_W-1:0]  val_nxt;
  logic [aadc_pkg::VAL_W-1:0]  val_r;
  logic                        snap_r;
  logic                        err_r;

  assign rev = cfg_r.reverse ? (W'(aadc_pkg::ONE_Q16) - dz_data.s) : dz_data.s;

  always_comb begin
    priority if (dz_data.span_err) begin
      val_nxt = '0;
    end else if (rev[W-1]) begin
      val_nxt = '1;
    end else begin
      val_nxt = rev[aadc_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dz_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r  <= val_nxt;
      snap_r <= dz_data.snap;
      err_r  <= dz_data.span_err;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_axis_value  = val_r;
  assign out_in_deadzone = snap_r;
  assign out_span_error  = err_r;

  // checks
  `AADC_ASSERT_IMPL(a_span_err_zero, out_valid && out_span_error, (out_axis_value == '0) && !out_in_deadzone, "span error result not zero")
  `AADC_ASSERT_IMPL(a_snap_center, out_valid && out_in_deadzone, out_axis_value == aadc_pkg::VAL_W'(aadc_pkg::CENTER_Q16), "snapped value off center")
  `AADC_ASSERT_IMPL(a_snap_needs_enable, out_valid && !cfg_r.deadzone_enable, !out_in_deadzone, "snap with deadzone disabled")
  `AADC_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable({out_axis_value, out_in_deadzone, out_span_error}), "stalled result changed")

endmodule

`default_nettype wire

@@ tb/analog_axis_deadzone_conditioner_tb.sv @@
// self-checking testbench of the analog axis deadzone conditioner
`timescale 1ns / 1ps

module analog_axis_deadzone_conditioner_tb;

  // fixed-point landmarks of the conditioned value
  localparam longint Q16_ONE = 65536;
  localparam longint Q16_MID = 32768;
  localparam longint DZ_LIMIT = 32768;
  localparam longint DZ_MIN_GAP = 7;

  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 45;
  localparam int PRESSURE_PHASE = 2;
  localparam int PRESSURE_ITEMS = 120;
  localparam int PAUSE_PHASE = 5;
  localparam int IDLE_PCT = 17;

  typedef struct packed {
    logic [15:0] value;
    logic        snapped;
    logic        span_err;
  } axis_result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    aadc_pkg::cfg_idx_t idx;
    logic [15:0]        data;
    bit                 pinned;
    axis_result_t       want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_raw_sample;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_axis_value;
  logic        out_in_deadzone;
  logic        out_span_error;

  aadc_pkg::cfg_t regs;
  axis_result_t   due_values[$];
  plan_row_t      plan[$];
  int             mismatches = 0;
  int             quiet = 0;
  bit             calm = 1'b0;
  bit             hold_ask = 1'b0;

  analog_axis_deadzone_conditioner u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_sample  (in_raw_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_axis_value (out_axis_value),
    .out_in_deadzone(out_in_deadzone),
    .out_span_error (out_span_error)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected conditioned value of one raw sample under the current registers
  function automatic axis_result_t condition_sample(logic [15:0] raw_bits);
    longint raw, num, den, s, mag, gap, off, dz;
    axis_result_t r;
    r.value = '0;
    r.snapped = 1'b0;
    r.span_err = 1'b0;
    raw = longint'($signed(raw_bits));
    dz = longint'(regs.deadzone);
    den = (longint'($signed(regs.axis_max)) - longint'($signed(regs.axis_min))) * 256;
    if (den == 0) begin
      r.span_err = 1'b1;
      return r;
    end
    num = raw * longint'(regs.gain) - longint'($signed(regs.axis_min)) * 256;
    // negative span flips both sides so the division stays positive
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num <= 0) s = 0;
    else if (num >= den) s = Q16_ONE;
    else s = (num * Q16_ONE) / den;
    // deadzone snap, else linear rescale over the rest of the half range
    if (regs.deadzone_enable && dz > 0 && dz < DZ_LIMIT) begin
      mag = (s < Q16_MID) ? Q16_MID - s : s - Q16_MID;
      gap = DZ_LIMIT - dz;
      if (mag < dz) begin
        s = Q16_MID;
        r.snapped = 1'b1;
      end else if (gap >= DZ_MIN_GAP) begin
        off = ((mag - dz) * Q16_MID) / gap;
        s = (s > Q16_MID) ? Q16_MID + off : Q16_MID - off;
        if (s < 0) s = 0;
        if (s > Q16_ONE) s = Q16_ONE;
      end
    end
    if (regs.reverse) s = Q16_ONE - s;
    if (s > Q16_ONE - 1) s = Q16_ONE - 1;
    r.value = s[15:0];
    return r;
  endfunction

  // raw sample aimed at the interesting part of the current axis range
  function automatic logic [15:0] pick_sample();
    longint lo, hi, t, mid, w;
    lo = longint'($signed(regs.axis_min));
    hi = longint'($signed(regs.axis_max));
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    case ($urandom_range(9))
      0, 1: return 16'($urandom);
      2: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      3, 4, 5: t = lo + longint'($urandom_range(int'(hi - lo)));
      default: begin
        mid = (lo + hi) / 2;
        w = (hi - lo) / 8 + 1;
        t = mid - w + longint'($urandom_range(int'(2 * w)));
      end
    endcase
    if (regs.gain == 0) return 16'($urandom);
    // undo the gain so the product lands near the chosen point
    t = (t * 256) / longint'(regs.gain);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[15:0];
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] %s", $time, what);
    mismatches++;
  endtask

  // one register write, shadow copy follows the same masking
  task automatic write_reg(input aadc_pkg::cfg_idx_t idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      aadc_pkg::CFG_AXIS_ENABLE:     regs.axis_enable = data[0];
      aadc_pkg::CFG_AXIS_MIN:        regs.axis_min = data;
      aadc_pkg::CFG_AXIS_MAX:        regs.axis_max = data;
      aadc_pkg::CFG_GAIN:            regs.gain = data;
      aadc_pkg::CFG_DEADZONE:        regs.deadzone = data[14:0];
      aadc_pkg::CFG_DEADZONE_ENABLE: regs.deadzone_enable = data[0];
      aadc_pkg::CFG_REVERSE:         regs.reverse = data[0];
      default: ;
    endcase
  endtask

  // offer one request, record its expected result once taken
  task automatic offer_sample(input logic [15:0] raw, input bit pinned,
                              input axis_result_t pin);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_raw_sample <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (regs.axis_enable) due_values.push_back(pinned ? pin : condition_sample(raw));
  endtask

  // stop sending, wait out every result and the pipeline tail
  task automatic settle();
    in_valid <= 1'b0;
    while (due_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_write(input aadc_pkg::cfg_idx_t idx, input logic [15:0] data);
    plan.push_back('{ROW_WRITE, idx, data, 1'b0, '0});
  endtask

  task automatic add_sample(input logic [15:0] raw);
    plan.push_back('{ROW_SAMPLE, aadc_pkg::CFG_AXIS_ENABLE, raw, 1'b0, '0});
  endtask

  task automatic add_pinned(input logic [15:0] raw, input logic [15:0] value,
                            input logic snapped, input logic span_err);
    axis_result_t w;
    w.value = value;
    w.snapped = snapped;
    w.span_err = span_err;
    plan.push_back('{ROW_SAMPLE, aadc_pkg::CFG_AXIS_ENABLE, raw, 1'b1, w});
  endtask

  // random register setting, biased toward the edges
  task automatic roll_setup(input bit force_on);
    int lo, hi, w;
    logic [15:0] g, dz;
    case ($urandom_range(9))
      0, 1: begin
        lo = -32768;
        hi = 32767;
      end
      2: begin
        lo = $urandom_range(65535) - 32768;
        hi = lo;
      end
      3: begin
        lo = $urandom_range(65535) - 32768;
        hi = $urandom_range(65535) - 32768;
      end
      default: begin
        lo = $urandom_range(60000) - 32768;
        w = $urandom_range(3000, 1);
        hi = (lo + w > 32767) ? 32767 : lo + w;
        // occasionally a reversed axis
        if ($urandom_range(4) == 0) begin
          w = lo;
          lo = hi;
          hi = w;
        end
      end
    endcase
    case ($urandom_range(9))
      0: g = 16'd0;
      1: g = 16'hffff;
      2: g = 16'($urandom_range(1023, 1));
      3: g = 16'($urandom);
      default: g = 16'd256;
    endcase
    case ($urandom_range(7))
      0: dz = 16'd0;
      1: dz = 16'd1;
      2: dz = 16'h7fff;
      3: dz = 16'($urandom_range(32762, 32760));
      4: dz = 16'($urandom_range(32767));
      default: dz = 16'($urandom_range(4096));
    endcase
    write_reg(aadc_pkg::CFG_AXIS_ENABLE,
              (force_on || $urandom_range(7) != 0) ? 16'd1 : 16'd0);
    write_reg(aadc_pkg::CFG_AXIS_MIN, lo[15:0]);
    write_reg(aadc_pkg::CFG_AXIS_MAX, hi[15:0]);
    write_reg(aadc_pkg::CFG_GAIN, g);
    write_reg(aadc_pkg::CFG_DEADZONE, dz);
    write_reg(aadc_pkg::CFG_DEADZONE_ENABLE, ($urandom_range(3) != 0) ? 16'd1 : 16'd0);
    write_reg(aadc_pkg::CFG_REVERSE, 16'($urandom_range(1)));
  endtask

  // result side: random stall, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_ask) begin
        hold_ask = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  // compare each result with the oldest expected one
  always @(posedge clk) begin
    axis_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (due_values.size() == 0) begin
        flag_mismatch($sformatf("result %0d with nothing expected", out_axis_value));
      end else begin
        exp_r = due_values.pop_front();
        if (out_axis_value !== exp_r.value)
          flag_mismatch($sformatf("axis_value %0d, expected %0d",
                                  out_axis_value, exp_r.value));
        if (out_in_deadzone !== exp_r.snapped)
          flag_mismatch($sformatf("in_deadzone %b, expected %b",
                                  out_in_deadzone, exp_r.snapped));
        if (out_span_error !== exp_r.span_err)
          flag_mismatch($sformatf("span_error %b, expected %b",
                                  out_span_error, exp_r.span_err));
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("analog_axis_deadzone_conditioner: mismatch");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    bit busy;
    int n;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= aadc_pkg::CFG_AXIS_ENABLE;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_raw_sample <= '0;
    busy = 1'b0;
    regs.axis_enable = 1'b0;
    regs.axis_min = 16'sd0;
    regs.axis_max = 16'sd255;
    regs.gain = 16'd256;
    regs.deadzone = '0;
    regs.deadzone_enable = 1'b0;
    regs.reverse = 1'b0;

    // reset state: axis disabled, range 0..255, unity gain
    add_sample(16'd100);
    add_write(aadc_pkg::CFG_AXIS_ENABLE, 16'd1);
    add_pinned(16'd0, 16'd0, 1'b0, 1'b0);
    add_pinned(16'd255, 16'hffff, 1'b0, 1'b0);
    add_pinned(16'h8000, 16'd0, 1'b0, 1'b0);
    add_pinned(16'h7fff, 16'hffff, 1'b0, 1'b0);
    add_sample(16'd128);
    add_sample(16'd1);
    // reversed output
    add_write(aadc_pkg::CFG_REVERSE, 16'd1);
    add_pinned(16'd0, 16'hffff, 1'b0, 1'b0);
    add_pinned(16'd255, 16'd0, 1'b0, 1'b0);
    // zero span ignores reverse
    add_write(aadc_pkg::CFG_AXIS_MAX, 16'd0);
    add_pinned(16'd1234, 16'd0, 1'b0, 1'b1);
    // full signed range with a deadzone
    add_write(aadc_pkg::CFG_REVERSE, 16'd0);
    add_write(aadc_pkg::CFG_AXIS_MIN, 16'h8000);
    add_write(aadc_pkg::CFG_AXIS_MAX, 16'h7fff);
    add_write(aadc_pkg::CFG_DEADZONE, 16'd1000);
    add_write(aadc_pkg::CFG_DEADZONE_ENABLE, 16'd1);
    add_pinned(16'd0, 16'd32768, 1'b1, 1'b0);
    add_pinned(16'h8000, 16'd0, 1'b0, 1'b0);
    add_pinned(16'h7fff, 16'hffff, 1'b0, 1'b0);
    add_sample(16'd500);
    add_sample(16'd5000);
    add_sample(16'hec78);
    // largest deadzone, gap too small to rescale
    add_write(aadc_pkg::CFG_DEADZONE, 16'h7fff);
    add_sample(16'd0);
    add_sample(16'h7fff);
    add_sample(16'h8000);
    // smallest usable gap
    add_write(aadc_pkg::CFG_DEADZONE, 16'd32761);
    add_sample(16'h7fff);
    // deadzone switched off
    add_write(aadc_pkg::CFG_DEADZONE_ENABLE, 16'd0);
    add_sample(16'd0);
    // negative span with gain extremes
    add_write(aadc_pkg::CFG_AXIS_MIN, 16'd100);
    add_write(aadc_pkg::CFG_AXIS_MAX, 16'hff9c);
    add_write(aadc_pkg::CFG_GAIN, 16'd0);
    add_sample(16'd77);
    add_write(aadc_pkg::CFG_GAIN, 16'hffff);
    add_sample(16'd1);
    add_sample(16'hffff);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (busy) settle();
        busy = 1'b0;
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        offer_sample(plan[i].data, plan[i].pinned, plan[i].want);
        busy = 1'b1;
      end
    end

    // random phases, each under a fresh register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      roll_setup(p == PRESSURE_PHASE);
      calm = (p == PRESSURE_PHASE) || (p == 9) || (p == 10);
      if (p == PRESSURE_PHASE) hold_ask = 1'b1;
      n = (p == PRESSURE_PHASE) ? PRESSURE_ITEMS : PHASE_ITEMS;
      for (int k = 0; k < n; k++) begin
        // sender pause until the pipeline has emptied
        if (p == PAUSE_PHASE && k == n / 2) settle();
        offer_sample(pick_sample(), 1'b0, '0);
      end
      calm = 1'b0;
    end

    settle();
    if (mismatches == 0) begin
      $display("analog_axis_deadzone_conditioner: match");
    end else begin
      $display("analog_axis_deadzone_conditioner: mismatch");
    end
    $finish;
  end

endmodule

@@ analog_axis_deadzone_conditioner.f @@
+incdir+rtl
rtl/aadc_pkg.sv
rtl/aadc_scale.sv
rtl/aadc_deadzone.sv
rtl/analog_axis_deadzone_conditioner.sv
tb/analog_axis_deadzone_conditioner_tb.sv
